>>> hdl/cdf_pkg.sv
// ----------------------------------------------------------------------------
// cdf_pkg: shared definitions for the container deframer
// Section and status codes, magic bytes and the word types passed between
// the input stage, the section tracker and the top level.
// ----------------------------------------------------------------------------
package cdf_pkg;

    localparam int TAG_BYTES_DEF = 16;

    localparam int SEC_W  = 4;
    localparam int STAT_W = 3;
    localparam int HLEN_W = 16;
    localparam int PLEN_W = 32;
    localparam int OFF_W  = 32;

    // Section codes.
    localparam logic [SEC_W-1:0] SEC_MAGIC   = 4'd0;
    localparam logic [SEC_W-1:0] SEC_VERSION = 4'd1;
    localparam logic [SEC_W-1:0] SEC_FLAGS   = 4'd2;
    localparam logic [SEC_W-1:0] SEC_HDRLEN  = 4'd3;
    localparam logic [SEC_W-1:0] SEC_HEADER  = 4'd4;
    localparam logic [SEC_W-1:0] SEC_PAYLEN  = 4'd5;
    localparam logic [SEC_W-1:0] SEC_PAYLOAD = 4'd6;
    localparam logic [SEC_W-1:0] SEC_TAG     = 4'd7;
    localparam logic [SEC_W-1:0] SEC_IGNORED = 4'd8;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_BUSY        = 3'd0;
    localparam logic [STAT_W-1:0] ST_OK          = 3'd1;
    localparam logic [STAT_W-1:0] ST_TRUNC_HDR   = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_MAGIC   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_VERSION = 3'd4;
    localparam logic [STAT_W-1:0] ST_TRUNC_AREA  = 3'd5;
    localparam logic [STAT_W-1:0] ST_TRUNC_PAY   = 3'd6;

    localparam logic [7:0] MAGIC_BYTES [4] = '{8'h57, 8'h43, 8'h50, 8'h58};

    localparam int OUT_DATA_W = 64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_cdf_item;

    typedef struct packed {
        logic [SEC_W-1:0]  section;
        logic [7:0]        byte_out;
        logic [STAT_W-1:0] status;
        logic [HLEN_W-1:0] header_length;
        logic [PLEN_W-1:0] payload_length;
    } t_cdf_result;

endpackage

>>> hdl/container_deframer.sv
// Each accepted byte moves from the input register to the output register.
// Throughput: one byte per cycle; with the output stalled, the input register takes
// one more byte and then holds tready low until the waiting result is accepted.
// The section tracker's offset add and compare sit between the two registers.
// Reset: i_rst_n is synchronous and active low; it clears the section state, the
// length registers and both valid flags; each tlast word clears the first two only.
// ----------------------------------------------------------------------------
// container_deframer: container file byte-stream splitter and checker
// Input register, section tracker and output register in one pipeline.
// ----------------------------------------------------------------------------
module container_deframer #(
    parameter int TAG_BYTES = cdf_pkg::TAG_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  logic        i_s_axis_tlast,  // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] byte_out, [10:8] status, [26:11] header_length,
    // [58:27] payload_length, [63:59] zero
    output logic [cdf_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [cdf_pkg::SEC_W-1:0]      o_m_axis_tuser  // [3:0] section
);

    cdf_pkg::t_cdf_item   s_item;
    cdf_pkg::t_cdf_item   stage_item;
    cdf_pkg::t_cdf_result core_result;
    cdf_pkg::t_cdf_result r_out;
    logic                 stage_valid;
    logic                 advance;
    logic                 r_out_valid;

    assign s_item.data_byte = i_s_axis_tdata;
    assign s_item.last_byte = i_s_axis_tlast;

    assign advance = stage_valid && (!r_out_valid || i_m_axis_tready);

    cdf_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (s_item),
        .o_valid (stage_valid),
        .i_take  (advance),
        .o_item  (stage_item)
    );

    cdf_core #(
        .TAG_BYTES (TAG_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (advance),
        .i_item   (stage_item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.section;
    assign o_m_axis_tdata  = {5'd0, r_out.payload_length, r_out.header_length,
                              r_out.status, r_out.byte_out};

endmodule

>>> hdl/cdf_in_stage.sv
// ----------------------------------------------------------------------------
// cdf_in_stage: input register
// Holds one accepted word until the section tracker consumes it.
// ----------------------------------------------------------------------------
module cdf_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  cdf_pkg::t_cdf_item   i_item,
    output logic                 o_valid,
    input  logic                 i_take,
    output cdf_pkg::t_cdf_item   o_item
);

    logic               r_valid;
    cdf_pkg::t_cdf_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> hdl/cdf_core.sv
// ----------------------------------------------------------------------------
// cdf_core: section tracker
// Tags each byte with its section, latches the length fields, checks magic
// and version and works out the status of the word.
// ----------------------------------------------------------------------------
module cdf_core #(
    parameter int TAG_BYTES = cdf_pkg::TAG_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  cdf_pkg::t_cdf_item    i_item,
    output cdf_pkg::t_cdf_result  o_result
);

    logic [cdf_pkg::SEC_W-1:0]  r_section, n_section;
    logic [cdf_pkg::OFF_W-1:0]  r_offset,  n_offset;
    logic [cdf_pkg::HLEN_W-1:0] r_hdr_len, n_hdr_len;
    logic [cdf_pkg::PLEN_W-1:0] r_pay_len, n_pay_len;
    logic                       r_magic_bad, n_magic_bad;
    logic                       r_ver_bad,   n_ver_bad;
    logic [cdf_pkg::STAT_W-1:0] r_status,  n_status;

    logic [cdf_pkg::OFF_W:0]    sec_len;
    logic                       sec_done;
    logic [cdf_pkg::SEC_W-1:0]  next_sec;
    logic [cdf_pkg::STAT_W-1:0] word_status;
    logic [7:0]                 data;

    assign data = i_item.data_byte;

    always_comb begin
        n_section   = r_section;
        n_offset    = r_offset;
        n_hdr_len   = r_hdr_len;
        n_pay_len   = r_pay_len;
        n_magic_bad = r_magic_bad;
        n_ver_bad   = r_ver_bad;
        n_status    = r_status;
        sec_len     = '0;

        case (r_section)
            cdf_pkg::SEC_MAGIC: begin
                if (data != cdf_pkg::MAGIC_BYTES[r_offset[1:0]]) begin
                    n_magic_bad = 1'b1;
                end
                sec_len = 33'd4;
            end
            cdf_pkg::SEC_VERSION: begin
                if (data != ((r_offset == '0) ? 8'd0 : 8'd1)) begin
                    n_ver_bad = 1'b1;
                end
                sec_len = 33'd2;
            end
            cdf_pkg::SEC_FLAGS: begin
                sec_len = 33'd1;
            end
            cdf_pkg::SEC_HDRLEN: begin
                n_hdr_len = {r_hdr_len[7:0], data};
                // The error is decided on the second length byte, the ninth
                // byte of the file.
                if (r_offset == 32'd1 && r_status == cdf_pkg::ST_BUSY) begin
                    if (r_magic_bad) begin
                        n_status = cdf_pkg::ST_BAD_MAGIC;
                    end else if (r_ver_bad) begin
                        n_status = cdf_pkg::ST_BAD_VERSION;
                    end
                end
                sec_len = 33'd2;
            end
            cdf_pkg::SEC_HEADER: begin
                sec_len = {17'd0, r_hdr_len};
            end
            cdf_pkg::SEC_PAYLEN: begin
                n_pay_len = {r_pay_len[23:0], data};
                sec_len = 33'd4;
            end
            cdf_pkg::SEC_PAYLOAD: begin
                sec_len = {1'b0, r_pay_len};
            end
            cdf_pkg::SEC_TAG: begin
                sec_len = 33'(TAG_BYTES);
            end
            default: begin
                sec_len = '0;
            end
        endcase

        sec_done = ({1'b0, r_offset} + 33'd1) >= sec_len;
        next_sec = r_section + 4'd1;
        if (next_sec == cdf_pkg::SEC_HEADER && n_hdr_len == '0) begin
            next_sec = cdf_pkg::SEC_PAYLEN;
        end
        if (next_sec == cdf_pkg::SEC_PAYLOAD && n_pay_len == '0) begin
            next_sec = cdf_pkg::SEC_TAG;
        end

        if (r_section != cdf_pkg::SEC_IGNORED) begin
            if (sec_done) begin
                n_section = next_sec;
                n_offset  = '0;
            end else begin
                n_offset  = r_offset + 32'd1;
            end
        end

        if (!i_item.last_byte) begin
            word_status = n_status;
        end else if (n_status != cdf_pkg::ST_BUSY) begin
            word_status = n_status;
        end else if (r_section < cdf_pkg::SEC_HDRLEN
                     || (r_section == cdf_pkg::SEC_HDRLEN && r_offset == '0)) begin
            word_status = cdf_pkg::ST_TRUNC_HDR;
        end else if (n_section == cdf_pkg::SEC_IGNORED) begin
            word_status = cdf_pkg::ST_OK;
        end else if (n_section <= cdf_pkg::SEC_PAYLEN) begin
            word_status = cdf_pkg::ST_TRUNC_AREA;
        end else begin
            word_status = cdf_pkg::ST_TRUNC_PAY;
        end
    end

    assign o_result.section        = r_section;
    assign o_result.byte_out       = data;
    assign o_result.status         = word_status;
    assign o_result.header_length  = n_hdr_len;
    assign o_result.payload_length = n_pay_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_item.last_byte)) begin
            r_section   <= cdf_pkg::SEC_MAGIC;
            r_offset    <= '0;
            r_hdr_len   <= '0;
            r_pay_len   <= '0;
            r_magic_bad <= 1'b0;
            r_ver_bad   <= 1'b0;
            r_status    <= cdf_pkg::ST_BUSY;
        end else if (i_valid) begin
            r_section   <= n_section;
            r_offset    <= n_offset;
            r_hdr_len   <= n_hdr_len;
            r_pay_len   <= n_pay_len;
            r_magic_bad <= n_magic_bad;
            r_ver_bad   <= n_ver_bad;
            r_status    <= n_status;
        end
    end

endmodule

>>> hdl/cdf_checker.sv
// ----------------------------------------------------------------------------
// cdf_checker: port-level checks for the container deframer
// Watches the output stream for stalls, padding and status consistency.
// ----------------------------------------------------------------------------
module cdf_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tvalid,
    input  logic                           i_tready,
    // [7:0] byte_out, [10:8] status, [26:11] header_length,
    // [58:27] payload_length, [63:59] zero
    input  logic [cdf_pkg::OUT_DATA_W-1:0] i_tdata,
    input  logic [cdf_pkg::SEC_W-1:0]      i_tuser   // [3:0] section
);

    // A stalled output word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && !i_tready |=>
            i_tvalid && $stable(i_tdata) && $stable(i_tuser))
        else $error("output word changed while stalled");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid |-> i_tdata[63:59] == 5'd0 && i_tuser <= cdf_pkg::SEC_IGNORED)
        else $error("bad padding or section code");

    // An accepted file can only end on a tag byte or a trailing byte.
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && i_tdata[10:8] == cdf_pkg::ST_OK |->
            i_tuser == cdf_pkg::SEC_TAG || i_tuser == cdf_pkg::SEC_IGNORED)
        else $error("ok status outside tag or trailing bytes");

    // A short header is only reported before the header length is complete.
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && i_tdata[10:8] == cdf_pkg::ST_TRUNC_HDR |->
            i_tuser <= cdf_pkg::SEC_HDRLEN)
        else $error("truncated header status after the length field");

endmodule

bind container_deframer cdf_checker u_cdf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (o_m_axis_tvalid),
    .i_tready (i_m_axis_tready),
    .i_tdata  (o_m_axis_tdata),
    .i_tuser  (o_m_axis_tuser)
);

>>> test/tb_container_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_container_deframer: self-checking bench for the container deframer
// A short table of hand-made files exercises short headers, the magic and
// version checks and the largest header length. Random files follow: mostly
// well-formed containers with random content, some cut short or corrupted,
// some with huge length fields, and some plain noise. Every output word is
// compared field by field against a behavioral predictor or hand-typed value.
// ----------------------------------------------------------------------------
module tb_container_deframer;

    localparam int TAG_LEN      = cdf_pkg::TAG_BYTES_DEF;
    localparam int WORD_TARGET  = 1650;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 40;

    logic                           i_clk;
    logic                           i_rst_n         = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [7:0]                     i_s_axis_tdata  = 8'h00;  // [7:0] data_byte
    logic                           i_s_axis_tlast  = 1'b0;   // last_byte
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b1;
    // [7:0] byte_out, [10:8] status, [26:11] header_length,
    // [58:27] payload_length, [63:59] zero
    logic [cdf_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [cdf_pkg::SEC_W-1:0]      o_m_axis_tuser;           // [3:0] section

    container_deframer #(
        .TAG_BYTES (TAG_LEN)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Section tracker model
    // ------------------------------------------------------------------------
    logic [cdf_pkg::SEC_W-1:0]  trk_section;
    logic [31:0]                trk_offset;
    logic [15:0]                trk_hdr_len;
    logic [31:0]                trk_pay_len;
    logic                       trk_magic_bad;
    logic                       trk_version_bad;
    logic [cdf_pkg::STAT_W-1:0] trk_status;

    cdf_pkg::t_cdf_result predicted_words[$];
    int                   mismatches = 0;
    int                   words_sent = 0;
    bit                   src_burst  = 1'b0;
    bit                   sink_burst = 1'b0;

    function automatic void clear_tracker();
        trk_section     = cdf_pkg::SEC_MAGIC;
        trk_offset      = '0;
        trk_hdr_len     = '0;
        trk_pay_len     = '0;
        trk_magic_bad   = 1'b0;
        trk_version_bad = 1'b0;
        trk_status      = cdf_pkg::ST_BUSY;
    endfunction

    function automatic cdf_pkg::t_cdf_result predict_word(input logic [7:0] b,
                                                          input logic last);
        cdf_pkg::t_cdf_result       res;
        logic [cdf_pkg::SEC_W-1:0]  sec;
        logic [cdf_pkg::SEC_W-1:0]  nxt;
        logic [31:0]                off;
        logic [32:0]                span;
        logic [cdf_pkg::STAT_W-1:0] st;
        sec  = (trk_section > cdf_pkg::SEC_IGNORED) ? cdf_pkg::SEC_IGNORED : trk_section;
        off  = trk_offset;
        span = '0;
        case (sec)
            cdf_pkg::SEC_MAGIC: begin
                if (b != cdf_pkg::MAGIC_BYTES[off[1:0]]) trk_magic_bad = 1'b1;
                span = 33'd4;
            end
            cdf_pkg::SEC_VERSION: begin
                // Big-endian version 1: a zero byte, then a one.
                if (b != ((off == 0) ? 8'h00 : 8'h01)) trk_version_bad = 1'b1;
                span = 33'd2;
            end
            cdf_pkg::SEC_FLAGS: span = 33'd1;
            cdf_pkg::SEC_HDRLEN: begin
                trk_hdr_len = {trk_hdr_len[7:0], b};
                if (off == 1 && trk_status == cdf_pkg::ST_BUSY) begin
                    if (trk_magic_bad) trk_status = cdf_pkg::ST_BAD_MAGIC;
                    else if (trk_version_bad) trk_status = cdf_pkg::ST_BAD_VERSION;
                end
                span = 33'd2;
            end
            cdf_pkg::SEC_HEADER:  span = {17'd0, trk_hdr_len};
            cdf_pkg::SEC_PAYLEN: begin
                trk_pay_len = {trk_pay_len[23:0], b};
                span = 33'd4;
            end
            cdf_pkg::SEC_PAYLOAD: span = {1'b0, trk_pay_len};
            cdf_pkg::SEC_TAG:     span = 33'(TAG_LEN);
            default:              span = '0;
        endcase

        if (sec != cdf_pkg::SEC_IGNORED) begin
            if ({1'b0, off} + 33'd1 >= span) begin
                nxt = sec + 4'd1;
                // Empty header or payload sections are skipped entirely.
                if (nxt == cdf_pkg::SEC_HEADER && trk_hdr_len == 0) nxt = cdf_pkg::SEC_PAYLEN;
                if (nxt == cdf_pkg::SEC_PAYLOAD && trk_pay_len == 0) nxt = cdf_pkg::SEC_TAG;
                trk_section = nxt;
                trk_offset  = '0;
            end else begin
                trk_offset = off + 32'd1;
            end
        end

        if (!last) st = trk_status;
        else if (trk_status != cdf_pkg::ST_BUSY) st = trk_status;
        else if (sec < cdf_pkg::SEC_HDRLEN || (sec == cdf_pkg::SEC_HDRLEN && off == 0))
            st = cdf_pkg::ST_TRUNC_HDR;
        else if (trk_section == cdf_pkg::SEC_IGNORED) st = cdf_pkg::ST_OK;
        else if (trk_section <= cdf_pkg::SEC_PAYLEN) st = cdf_pkg::ST_TRUNC_AREA;
        else st = cdf_pkg::ST_TRUNC_PAY;

        res.section        = sec;
        res.byte_out       = b;
        res.status         = st;
        res.header_length  = trk_hdr_len;
        res.payload_length = trk_pay_len;
        if (last) clear_tracker();
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input cdf_pkg::t_cdf_result want);
        int                   gap;
        cdf_pkg::t_cdf_result pred;
        gap = src_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        // The model always advances; hand-typed rows override its answer.
        pred = predict_word(b, last);
        predicted_words.insert(predicted_words.size(), typed ? want : pred);
        words_sent++;
    endtask

    typedef struct {
        logic [7:0]           data;
        logic                 last;
        logic                 typed;
        cdf_pkg::t_cdf_result want;
    } t_stim_row;

    t_stim_row stim_rows[$];

    function automatic void add_row(input logic [7:0] d, input logic l,
                                    input logic typed = 1'b0,
                                    input logic [cdf_pkg::SEC_W-1:0] sec = cdf_pkg::SEC_MAGIC,
                                    input logic [cdf_pkg::STAT_W-1:0] st = cdf_pkg::ST_BUSY,
                                    input logic [15:0] hlen = '0,
                                    input logic [31:0] plen = '0);
        t_stim_row row;
        row.data                = d;
        row.last                = l;
        row.typed               = typed;
        row.want.section        = sec;
        row.want.byte_out       = d;
        row.want.status         = st;
        row.want.header_length  = hlen;
        row.want.payload_length = plen;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    logic [7:0] file_bytes[$];
    int         file_cap;

    function automatic void put(input logic [7:0] b);
        if (file_bytes.size() < file_cap) file_bytes.insert(file_bytes.size(), b);
    endfunction

    task automatic build_file();
        int          kind;
        int          n;
        int          j;
        logic [15:0] hlen;
        logic [31:0] plen;
        longint      k;
        file_bytes.delete();
        file_cap = 1000;
        kind     = $urandom_range(0, 99);
        if (kind < 15) begin
            n = $urandom_range(1, 14);
            repeat (n) put(8'($urandom_range(0, 255)));
        end else begin
            if (kind < 30) begin
                // Wide length fields; the file is cut long before the payload length runs out.
                hlen     = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 8))
                                                       : 16'($urandom_range(0, 65535));
                plen     = $urandom;
                file_cap = $urandom_range(10, 60);
            end else begin
                hlen = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
                plen = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 8));
            end
            for (j = 0; j < 4; j++) put(cdf_pkg::MAGIC_BYTES[j]);
            put(8'h00);
            put(8'h01);
            put(8'($urandom_range(0, 255)));
            put(hlen[15:8]);
            put(hlen[7:0]);
            for (k = 0; k < hlen && file_bytes.size() < file_cap; k++)
                put(8'($urandom_range(0, 255)));
            put(plen[31:24]);
            put(plen[23:16]);
            put(plen[15:8]);
            put(plen[7:0]);
            for (k = 0; k < plen && file_bytes.size() < file_cap; k++)
                put(8'($urandom_range(0, 255)));
            repeat (TAG_LEN) put(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > n) void'(file_bytes.pop_back());
            end
            // Occasionally corrupt a magic or version byte.
            if ($urandom_range(0, 6) == 0) begin
                j = $urandom_range(0, 5);
                if (j < file_bytes.size()) file_bytes[j] ^= 8'($urandom_range(1, 255));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------------
    cdf_pkg::t_cdf_result want_word;
    int                   sink_hold = 0;
    int                   sink_stall;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (predicted_words.size() == 0) begin
                report_mismatch("unpredicted word", o_m_axis_tdata, '0);
            end else begin
                want_word = predicted_words.pop_front();
                if (o_m_axis_tuser !== want_word.section)
                    report_mismatch("section", 64'(o_m_axis_tuser), 64'(want_word.section));
                if (o_m_axis_tdata[7:0] !== want_word.byte_out)
                    report_mismatch("byte_out", 64'(o_m_axis_tdata[7:0]),
                                    64'(want_word.byte_out));
                if (o_m_axis_tdata[10:8] !== want_word.status)
                    report_mismatch("status", 64'(o_m_axis_tdata[10:8]),
                                    64'(want_word.status));
                if (o_m_axis_tdata[26:11] !== want_word.header_length)
                    report_mismatch("header_length", 64'(o_m_axis_tdata[26:11]),
                                    64'(want_word.header_length));
                if (o_m_axis_tdata[58:27] !== want_word.payload_length)
                    report_mismatch("payload_length", 64'(o_m_axis_tdata[58:27]),
                                    64'(want_word.payload_length));
                if (o_m_axis_tdata[63:59] !== 5'd0)
                    report_mismatch("tdata padding", 64'(o_m_axis_tdata[63:59]), '0);
            end
            if ($urandom_range(0, 63) == 0) sink_burst = !sink_burst;
            sink_stall = sink_burst ? 0 : $urandom_range(0, 7);
            if (sink_stall == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                sink_hold       <= sink_stall;
            end
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            if (sink_hold == 1) i_m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int i;
        clear_tracker();

        // A file of a single byte ends inside the magic.
        add_row(8'hFF, 1'b1, 1'b1, cdf_pkg::SEC_MAGIC, cdf_pkg::ST_TRUNC_HDR);
        // Bad magic, but the file ends on the first length byte: still short.
        add_row(8'h57, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h50, 1'b0);
        add_row(8'h58, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h01, 1'b0);
        add_row(8'h7F, 1'b0);
        add_row(8'h00, 1'b1, 1'b1, cdf_pkg::SEC_HDRLEN, cdf_pkg::ST_TRUNC_HDR, 16'h0000);
        // Bad magic and bad version together: the magic error takes priority.
        add_row(8'h58, 1'b0);
        add_row(8'h43, 1'b0);
        add_row(8'h50, 1'b0);
        add_row(8'h57, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h12, 1'b0);
        add_row(8'h34, 1'b1, 1'b1, cdf_pkg::SEC_HDRLEN, cdf_pkg::ST_BAD_MAGIC, 16'h1234);
        // Good magic, version zero, largest header length.
        add_row(8'h57, 1'b0);
        add_row(8'h43, 1'b0);
        add_row(8'h50, 1'b0);
        add_row(8'h58, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'hFF, 1'b1, 1'b1, cdf_pkg::SEC_HDRLEN, cdf_pkg::ST_BAD_VERSION, 16'hFFFF);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < stim_rows.size(); i++) begin
            src_burst = ($urandom_range(0, 3) == 0);
            send_byte(stim_rows[i].data, stim_rows[i].last, stim_rows[i].typed,
                      stim_rows[i].want);
        end

        while (words_sent < WORD_TARGET) begin
            build_file();
            src_burst = ($urandom_range(0, 4) == 0);
            for (i = 0; i < file_bytes.size(); i++)
                send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;

        while (predicted_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
